FILE: rtl/pdau_pkg.sv
// pdau_pkg: shared constants, status codes, register indexes and pipeline stage map
// for the pixel disturbance alert update core
// no dependencies
package pdau_pkg;

	// field widths
	localparam int IN_W  = 120;
	localparam int OUT_W = 104;

	// fixed limits of the record
	localparam int ANOM_MAX  = 100;
	localparam int PCT_FULL  = 100;
	localparam int COUNT_CAP = 253;
	localparam int CONF_CAP  = 65000;
	localparam int NO_HIST   = 255;

	// register reset values
	localparam logic [15:0] RST_CURRENT_DAY  = 16'd0;
	localparam logic [6:0]  RST_MIN_ANOMALY  = 7'd10;
	localparam logic [6:0]  RST_HIGH_ANOMALY = 7'd50;
	localparam logic [15:0] RST_CONFIRM      = 16'd400;
	localparam logic [15:0] RST_WINDOW       = 16'd365;
	localparam logic [6:0]  RST_DROP         = 7'd33;

	typedef enum logic [2:0] {
		CFG_CURRENT_DAY  = 3'd0,
		CFG_MIN_ANOMALY  = 3'd1,
		CFG_HIGH_ANOMALY = 3'd2,
		CFG_CONFIRM      = 3'd3,
		CFG_WINDOW       = 3'd4,
		CFG_DROP         = 3'd5
	} cfg_idx_t;

	// status codes
	localparam logic [7:0] ST_NONE      = 8'd0;
	localparam logic [7:0] ST_LOW_PROV  = 8'd1;
	localparam logic [7:0] ST_LOW_CONF  = 8'd2;
	localparam logic [7:0] ST_HIGH_PROV = 8'd3;
	localparam logic [7:0] ST_HIGH_CONF = 8'd4;

	// pipeline stage map
	localparam int ST_PRE     = 1;   // stale check, non-loss count dividend
	localparam int ST_PN0     = 2;   // non-loss count division, 3 bits a stage
	localparam int PN_STAGES  = 5;
	localparam int PN_BITS    = 3;
	localparam int ST_BR      = ST_PN0 + PN_STAGES;  // loss branch
	localparam int ST_M1      = ST_BR + 1;           // multiplies, percent division start
	localparam int ST_M2      = ST_M1 + 1;
	localparam int ST_M3      = ST_M2 + 1;
	localparam int ST_M4      = ST_M3 + 1;
	localparam int PCT_BITS   = 7;
	localparam int ST_C0      = ST_M4 + 1;           // confidence division start
	localparam int CONF_BITS  = 16;
	localparam int ST_FIN     = ST_C0 + CONF_BITS + 1;
	localparam int PIPE_DEPTH = ST_FIN;

	typedef struct packed {
		logic        nodata;
		logic [7:0]  anom;
		logic [7:0]  veg;
		logic [7:0]  status;
		logic [7:0]  mx;
		logic [15:0] conf;
		logic [15:0] onset;
		logic [7:0]  count;
		logic [6:0]  pct;
		logic [15:0] dur;
		logic [15:0] last;
		logic [7:0]  hist;
		logic [7:0]  pc;
		logic        pn_neg;
		logic [6:0]  pn_dvs;
		logic [6:0]  pn_rem;
		logic [14:0] pn_sh;
		logic        cond;
		logic [14:0] ca;
		logic        pdo;
		logic [14:0] pnum;
		logic [14:0] pden;
		logic [14:0] prem;
		logic [6:0]  psh;
		logic        povf;
		logic [30:0] prod1;
		logic [15:0] pcsq;
		logic [15:0] cnt2;
		logic [23:0] tm;
		logic [31:0] cden;
		logic [31:0] csum;
		logic [47:0] cnum;
		logic [31:0] crem;
		logic [15:0] csh;
		logic        covf;
	} item_t;

endpackage

FILE: rtl/pixel_disturbance_alert_update_core.sv
// pixel_disturbance_alert_update_core: pipelined vegetation-loss alert record update
// depends on pdau_pkg
//
// usage
//  - slave stream (s_tvalid/s_tready/s_tdata) carries one request per pixel: the
//    current anomaly, vegetation value and the previous alert record
//  - master stream (m_tvalid/m_tready/m_tdata) returns the updated record, one per request
//  - cfg_en/cfg_index/cfg_data write the six settings; write only while idle
//  - one request per cycle sustained while m_tready stays high
//  - the depth is set by the staged divisions: non-loss count (5 stages),
//    percent (8 stages, overlapped) and confidence (17 stages)
//  - each stage only holds when it is full and the stage after it holds, so
//    bubbles collapse and new requests are taken while a result waits
//  - reset clears all valid bits and loads the setting defaults
//  - a stall of m_tready freezes the full stages ahead of the first empty one; nothing is lost or repeated
module pixel_disturbance_alert_update_core
	import pdau_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_en,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	// anomaly, veg_value, prev_status, prev_max, prev_conf, prev_onset_day,
	// prev_count, prev_percent, prev_duration, prev_last_day, prev_hist_veg
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// new_status, new_max, new_conf, new_onset_day, new_count, new_percent,
	// new_duration, new_last_day, new_hist_veg
	output logic [OUT_W-1:0]  m_tdata
);

	// settings
	logic [15:0] cur_day_q;
	logic [6:0]  min_anom_q;
	logic [6:0]  high_anom_q;
	logic [15:0] confirm_q;
	logic [15:0] window_q;
	logic [6:0]  drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= RST_CURRENT_DAY;
			min_anom_q  <= RST_MIN_ANOMALY;
			high_anom_q <= RST_HIGH_ANOMALY;
			confirm_q   <= RST_CONFIRM;
			window_q    <= RST_WINDOW;
			drop_q      <= RST_DROP;
		end else if (cfg_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CURRENT_DAY:  cur_day_q   <= cfg_data;
				CFG_MIN_ANOMALY:  min_anom_q  <= cfg_data[6:0];
				CFG_HIGH_ANOMALY: high_anom_q <= cfg_data[6:0];
				CFG_CONFIRM:      confirm_q   <= cfg_data;
				CFG_WINDOW:       window_q    <= cfg_data;
				CFG_DROP:         drop_q      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// cleared record, used for a stale record and for a dropped provisional alert
	function automatic item_t clear_rec(item_t r);
		item_t o;
		o        = r;
		o.status = ST_NONE;
		o.pct    = '0;
		o.count  = '0;
		o.mx     = '0;
		o.conf   = '0;
		o.onset  = '0;
		o.dur    = '0;
		o.hist   = 8'(NO_HIST);
		return o;
	endfunction

	item_t               item_s [0:PIPE_DEPTH];
	logic [PIPE_DEPTH:0] vld_s;
	logic [PIPE_DEPTH:1] en;

	// unpack the request into stage zero
	always_comb begin
		item_s[0]        = '0;
		item_s[0].anom   = s_tdata[7:0];
		item_s[0].veg    = s_tdata[15:8];
		item_s[0].status = s_tdata[23:16];
		item_s[0].mx     = s_tdata[31:24];
		item_s[0].conf   = s_tdata[47:32];
		item_s[0].onset  = s_tdata[63:48];
		item_s[0].count  = s_tdata[71:64];
		item_s[0].pct    = s_tdata[78:72];
		item_s[0].dur    = s_tdata[94:79];
		item_s[0].last   = s_tdata[110:95];
		item_s[0].hist   = s_tdata[118:111];
	end
	assign vld_s[0] = s_tvalid;

	// a stage loads when it is empty or the next one moves
	assign en[PIPE_DEPTH] = !vld_s[PIPE_DEPTH] || m_tready;
	for (genvar j = 1; j < PIPE_DEPTH; j++) begin : g_en
		assign en[j] = !vld_s[j] || en[j+1];
	end
	assign s_tready = en[1];

	for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_stage
		item_t nx;

		always_comb begin : c_step
			item_t             x;
			logic signed [17:0] age;
			logic [6:0]        pd;
			logic [7:0]        t8;
			logic              ge;
			logic signed [16:0] pnv;
			logic [7:0]        cnt_new;
			logic [15:0]       pt;
			logic [32:0]       ct;
			logic [15:0]       qc;
			logic [6:0]        qp;
			x       = item_s[k-1];
			nx      = x;
			age     = '0;
			pd      = '0;
			t8      = '0;
			ge      = 1'b0;
			pnv     = '0;
			cnt_new = '0;
			pt      = '0;
			ct      = '0;
			qc      = '0;
			qp      = '0;

			// stale record test and the non-loss count dividend
			if (k == ST_PRE) begin
				nx.nodata = x.anom > 8'(ANOM_MAX);
				if (!nx.nodata) begin
					nx.last = cur_day_q;
					age = $signed({2'b00, cur_day_q}) - $signed({2'b00, x.onset});
					if (age > $signed({2'b00, window_q}))
						nx = clear_rec(nx);
				end
				nx.pc     = nx.count;
				nx.pn_neg = nx.pct > 7'(PCT_FULL);
				nx.pn_rem = '0;
				pd        = nx.pn_neg ? nx.pct - 7'(PCT_FULL) : 7'(PCT_FULL) - nx.pct;
				if (nx.pct == '0) begin
					nx.pn_dvs = 7'd1;
					nx.pn_sh  = '0;
				end else begin
					nx.pn_dvs = nx.pct;
					nx.pn_sh  = 15'(pd) * 15'(nx.count);
				end
			end

			// non-loss count: magnitude division, restoring
			if (k >= ST_PN0 && k < ST_PN0 + PN_STAGES) begin
				for (int i = 0; i < PN_BITS; i++) begin
					t8 = {nx.pn_rem, nx.pn_sh[14]};
					ge = t8 >= {1'b0, nx.pn_dvs};
					nx.pn_rem = ge ? 7'(t8 - {1'b0, nx.pn_dvs}) : t8[6:0];
					nx.pn_sh  = {nx.pn_sh[13:0], ge};
				end
			end

			// loss branch: onset, maximum, history, count, duration, percent division operands
			if (k == ST_BR) begin
				pnv = nx.pn_neg ? -$signed({2'b00, x.pn_sh}) : $signed({2'b00, x.pn_sh});
				nx.cond = (x.conf != '0) && (x.pc != '0) && (x.pct != '0);
				nx.ca   = 15'($signed({9'd0, x.pc}) + pnv);
				nx.pdo  = 1'b0;
				nx.pnum = '0;
				nx.pden = 15'd1;
				if (!x.nodata) begin
					if (x.anom >= {1'b0, min_anom_q}) begin
						if (x.onset == '0) begin
							nx.onset = cur_day_q;
							nx.mx    = x.anom;
							nx.hist  = x.veg + x.anom;
							nx.pct   = 7'(PCT_FULL);
							nx.count = 8'd1;
						end else begin
							if (x.anom > x.mx) begin
								nx.mx   = x.anom;
								nx.hist = x.veg + x.anom;
							end
							if (x.count < 8'(COUNT_CAP)) begin
								cnt_new  = x.count + 8'd1;
								nx.count = cnt_new;
								nx.pdo   = 1'b1;
								nx.pnum  = 15'(cnt_new) * 15'(PCT_FULL);
								nx.pden  = 15'($signed({9'd0, cnt_new}) + pnv);
							end
						end
						nx.dur = cur_day_q - nx.onset + 16'd1;
					end else if (x.pct != '0) begin
						nx.pdo  = 1'b1;
						nx.pnum = 15'(x.count) * 15'(PCT_FULL);
						nx.pden = 15'($signed({9'd0, x.pc}) + pnv + 17'sd1);
					end
				end
			end

			// confidence numerator and denominator products
			if (k == ST_M1) begin
				nx.prod1 = 31'(x.conf) * 31'(x.ca);
				nx.pcsq  = 16'(x.pc) * 16'(x.pc);
				nx.cnt2  = 16'(x.count) * 16'(x.count);
				// percent quotient above 127 saturates anyway
				nx.povf  = {7'd0, x.pnum[14:7]} >= x.pden;
				nx.prem  = {7'd0, x.pnum[14:7]};
				nx.psh   = x.pnum[6:0];
			end
			if (k == ST_M2) begin
				nx.tm   = 24'(x.anom) * 24'(x.pcsq);
				nx.cden = 32'(x.pcsq) * 32'({1'b0, x.ca} + 16'd1);
			end
			if (k == ST_M3)
				nx.csum = 32'(x.prod1) + 32'(x.tm);
			if (k == ST_M4)
				nx.cnum = 48'(x.csum) * 48'(x.cnt2);

			// percent division, one bit a stage
			if (k > ST_M1 && k <= ST_M1 + PCT_BITS) begin
				pt = {x.prem, x.psh[6]};
				ge = pt >= {1'b0, x.pden};
				nx.prem = ge ? 15'(pt - {1'b0, x.pden}) : pt[14:0];
				nx.psh  = {x.psh[5:0], ge};
			end

			// confidence division: overflow check on the high part, then 16 bits
			if (k == ST_C0) begin
				nx.covf = x.cnum[47:16] >= x.cden;
				nx.crem = x.cnum[47:16];
				nx.csh  = x.cnum[15:0];
			end
			if (k > ST_C0 && k <= ST_C0 + CONF_BITS) begin
				ct = {x.crem, x.csh[15]};
				ge = ct >= {1'b0, x.cden};
				nx.crem = ge ? 32'(ct - {1'b0, x.cden}) : ct[31:0];
				nx.csh  = {x.csh[14:0], ge};
			end

			// saturation, status hysteresis and provisional drop
			if (k == ST_FIN && !x.nodata) begin
				qc = (x.covf || x.csh > 16'(CONF_CAP)) ? 16'(CONF_CAP) : x.csh;
				nx.conf = x.cond ? qc : {8'd0, x.anom};
				qp = (x.povf || x.psh > 7'(PCT_FULL)) ? 7'(PCT_FULL) : x.psh;
				if (x.pdo)
					nx.pct = qp;
				priority if (x.mx >= {1'b0, high_anom_q}) begin
					if (nx.conf >= confirm_q)
						nx.status = ST_HIGH_CONF;
					else if (x.status != ST_HIGH_CONF)
						nx.status = ST_HIGH_PROV;
				end else if (x.mx >= {1'b0, min_anom_q}) begin
					if (nx.conf >= confirm_q)
						nx.status = ST_LOW_CONF;
					else if (x.status != ST_LOW_CONF)
						nx.status = ST_LOW_PROV;
				end else begin
					nx.status = ST_NONE;
				end
				if (nx.pct <= drop_q &&
				    (nx.status == ST_LOW_PROV || nx.status == ST_HIGH_PROV))
					nx = clear_rec(nx);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en[k])
				vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en[k])
				item_s[k] <= nx;
		end
	end

	// result
	assign m_tvalid = vld_s[PIPE_DEPTH];
	assign m_tdata  = {1'b0,
	                   item_s[PIPE_DEPTH].hist,
	                   item_s[PIPE_DEPTH].last,
	                   item_s[PIPE_DEPTH].dur,
	                   item_s[PIPE_DEPTH].pct,
	                   item_s[PIPE_DEPTH].count,
	                   item_s[PIPE_DEPTH].onset,
	                   item_s[PIPE_DEPTH].conf,
	                   item_s[PIPE_DEPTH].mx,
	                   item_s[PIPE_DEPTH].status};

endmodule
